// ----- hdl/cpr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the clock page replacement unit: widths, defaults, controller
// states and the command and status structs between controller and datapath.
// Depends on nothing.
package cpr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 4;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_SWEEP,
    ST_EVICT,
    ST_RESP
  } cpr_state_t;

  typedef struct packed {
    logic load;
    logic scan_next;
    logic do_hit;
    logic do_fill;
    logic sweep_clear;
    logic sweep_found;
    logic do_evict;
    logic emit;
  } cpr_cmd_t;

  typedef struct packed {
    logic used_zero;
    logic match;
    logic scan_last;
    logic full;
    logic use_set;
    logic out_free;
  } cpr_status_t;

endpackage

// ----- hdl/cpr_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the clock page replacement unit: valid, ready and the
// referenced page. Depends on cpr_pkg for the payload widths.
interface cpr_req_if;
  logic                        valid;
  logic                        ready;
  logic [cpr_pkg::PAGE_W-1:0]  page;
  logic                        last_ref;

  modport source (output valid, output page, output last_ref, input ready);
  modport sink (input valid, input page, input last_ref, output ready);
endinterface

// ----- hdl/cpr_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the clock page replacement unit: valid, ready and the
// outcome of one reference. Depends on cpr_pkg for the payload widths.
interface cpr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         fault;
  logic [cpr_pkg::FRAME_W-1:0]  frame;
  logic [cpr_pkg::PAGE_W-1:0]   evicted_page;
  logic [cpr_pkg::TOTAL_W-1:0]  fault_total;
  logic                         last_out;

  modport source (output valid, output hit, output fault, output frame,
                  output evicted_page, output fault_total, output last_out,
                  input ready);
  modport sink (input valid, input hit, input fault, input frame,
                input evicted_page, input fault_total, input last_out,
                output ready);
endinterface

// ----- hdl/clock_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// Top level of the clock (second-chance) page replacement unit.
// Depends on cpr_pkg, cpr_req_if, cpr_rsp_if, cpr_ctrl and cpr_datapath.
//
// Usage:
//   req carries one page reference per request (page, last_ref); rsp carries
//   one result per request (hit, fault, frame, evicted_page, fault_total,
//   last_out). Both use valid/ready; a transfer happens when both are high.
//   cfg_wr_en with cfg_wr_data sets the frame count and flushes the resident
//   set; write it only while no request is in flight.
// Steps: a hit scans the resident frames in order until the page matches; a
//   fill scans them all, then takes the next free frame; a replacement scans
//   them all, then the hand clears set use bits and moves on until it reaches
//   a clear one, whose frame is refilled and whose old page is evicted.
//   The frame memory is scanned one entry per cycle through its single read
//   port, and the hand examines one use bit per cycle.
// Reset clears the use bits, fill count, hand and fault counter at once and
// sets the frame count to 16; there is no clearing pass. A result sits in the
// output register until taken; a stalled receiver holds the unit in its
// response step, and the next request is accepted once the result moves.
module clock_page_replacement_unit #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [cpr_pkg::CFG_W-1:0] cfg_wr_data,
  cpr_req_if.sink                   req,
  cpr_rsp_if.source                 rsp
);

  cpr_pkg::cpr_cmd_t    cmd;
  cpr_pkg::cpr_status_t st;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_page     (req.page),
    .in_last     (req.last_ref),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_hit     (rsp.hit),
    .out_fault   (rsp.fault),
    .out_frame   (rsp.frame),
    .out_evicted (rsp.evicted_page),
    .out_total   (rsp.fault_total),
    .out_last    (rsp.last_out)
  );

endmodule

// ----- hdl/cpr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the clock page replacement unit.
// Depends on cpr_pkg for the state type and the command and status structs.
module cpr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cpr_pkg::cpr_status_t st,
  output cpr_pkg::cpr_cmd_t    cmd
);

  cpr_pkg::cpr_state_t state;
  cpr_pkg::cpr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = st.used_zero ? cpr_pkg::ST_MISS : cpr_pkg::ST_SCAN;
        end
      end
      cpr_pkg::ST_SCAN: begin
        if (st.match) begin
          state_next = cpr_pkg::ST_RESP;
        end else if (st.scan_last) begin
          state_next = cpr_pkg::ST_MISS;
        end
      end
      cpr_pkg::ST_MISS: begin
        state_next = st.full ? cpr_pkg::ST_SWEEP : cpr_pkg::ST_RESP;
      end
      cpr_pkg::ST_SWEEP: begin
        if (!st.use_set) begin
          state_next = cpr_pkg::ST_EVICT;
        end
      end
      cpr_pkg::ST_EVICT: begin
        state_next = cpr_pkg::ST_RESP;
      end
      cpr_pkg::ST_RESP: begin
        if (st.out_free) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cpr_pkg::ST_SCAN: begin
        cmd.do_hit    = st.match;
        cmd.scan_next = !st.match && !st.scan_last;
      end
      cpr_pkg::ST_MISS: begin
        cmd.do_fill = !st.full;
      end
      cpr_pkg::ST_SWEEP: begin
        cmd.sweep_clear = st.use_set;
        cmd.sweep_found = !st.use_set;
      end
      cpr_pkg::ST_EVICT: begin
        cmd.do_evict = 1'b1;
      end
      cpr_pkg::ST_RESP: begin
        cmd.emit = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/cpr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the clock page replacement unit: frame page memory, use bits,
// hand, counters, result and output registers. Depends on cpr_pkg.
module cpr_datapath #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cpr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [cpr_pkg::PAGE_W-1:0]    in_page,
  input  logic                          in_last,
  input  cpr_pkg::cpr_cmd_t             cmd,
  output cpr_pkg::cpr_status_t          st,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic                          out_fault,
  output logic [cpr_pkg::FRAME_W-1:0]   out_frame,
  output logic [cpr_pkg::PAGE_W-1:0]    out_evicted,
  output logic [cpr_pkg::TOTAL_W-1:0]   out_total,
  output logic                          out_last
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int KEY_W = (PAGE_BITS < cpr_pkg::PAGE_W) ? PAGE_BITS : cpr_pkg::PAGE_W;

  logic [cpr_pkg::CFG_W-1:0]   frame_count;
  logic [FRAMES-1:0]           use_bits;
  logic [CNT_W-1:0]            filled_count;
  logic [IDX_W-1:0]            hand;
  logic [cpr_pkg::TOTAL_W-1:0] fault_counter;

  logic [KEY_W-1:0]            key;
  logic                        last_ref;
  logic [IDX_W-1:0]            scan_idx;

  logic [KEY_W-1:0]            mem [FRAMES];
  logic [IDX_W-1:0]            rd_addr;
  logic [KEY_W-1:0]            rd_data;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;

  logic                        res_hit;
  logic                        res_fault;
  logic [IDX_W-1:0]            res_frame;
  logic [KEY_W-1:0]            res_evicted;
  logic [cpr_pkg::TOTAL_W-1:0] res_total;

  logic [CNT_W-1:0]            nf;
  logic [CNT_W-1:0]            used;
  logic [CNT_W-1:0]            hand_inc;
  logic [IDX_W-1:0]            hand_adv;
  logic [IDX_W-1:0]            fill_idx;
  logic [cpr_pkg::TOTAL_W-1:0] fault_inc;

  always_comb begin
    if (frame_count == '0) begin
      nf = CNT_W'(1);
    end else if (32'(frame_count) > FRAMES) begin
      nf = CNT_W'(FRAMES);
    end else begin
      nf = CNT_W'(frame_count);
    end
  end

  assign used      = (filled_count < nf) ? filled_count : nf;
  assign hand_inc  = CNT_W'(hand) + CNT_W'(1);
  assign hand_adv  = (hand_inc >= nf) ? '0 : IDX_W'(hand_inc);
  assign fill_idx  = IDX_W'(used);
  assign fault_inc = (fault_counter == '1) ? fault_counter : fault_counter + 32'd1;

  assign st.used_zero = (used == '0);
  assign st.match     = (rd_data == key);
  assign st.scan_last = (CNT_W'(scan_idx) == used - CNT_W'(1));
  assign st.full      = (used >= nf);
  assign st.use_set   = use_bits[hand];
  assign st.out_free  = !out_valid || out_ready;

  always_comb begin
    priority if (cmd.sweep_found) begin
      rd_addr = hand;
    end else if (cmd.scan_next) begin
      rd_addr = scan_idx + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  assign mem_we    = cmd.do_fill || cmd.do_evict;
  assign mem_waddr = cmd.do_fill ? fill_idx : hand;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= cpr_pkg::FRAME_COUNT_RESET;
      use_bits      <= '0;
      filled_count  <= '0;
      hand          <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_count  <= cfg_wr_data;
        use_bits     <= '0;
        filled_count <= '0;
        hand         <= '0;
      end
      if (cmd.do_hit) begin
        use_bits[scan_idx] <= 1'b1;
      end
      if (cmd.do_fill) begin
        use_bits[fill_idx] <= 1'b1;
        filled_count       <= used + CNT_W'(1);
      end
      if (cmd.sweep_clear) begin
        use_bits[hand] <= 1'b0;
        hand           <= hand_adv;
      end
      if (cmd.do_evict) begin
        use_bits[hand] <= 1'b1;
        hand           <= hand_adv;
        fault_counter  <= fault_inc;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // The final reference of a stream returns the set to its reset state.
      if (cmd.emit && last_ref) begin
        use_bits      <= '0;
        filled_count  <= '0;
        hand          <= '0;
        fault_counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= KEY_W'(in_page);
      last_ref <= in_last;
      scan_idx <= '0;
    end
    if (cmd.scan_next) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmd.do_hit) begin
      res_hit     <= 1'b1;
      res_fault   <= 1'b0;
      res_frame   <= scan_idx;
      res_evicted <= '0;
      res_total   <= fault_counter;
    end
    if (cmd.do_fill) begin
      res_hit     <= 1'b0;
      res_fault   <= 1'b0;
      res_frame   <= fill_idx;
      res_evicted <= '0;
      res_total   <= fault_counter;
    end
    if (cmd.do_evict) begin
      res_hit     <= 1'b0;
      res_fault   <= 1'b1;
      res_frame   <= hand;
      res_evicted <= rd_data;
      res_total   <= fault_inc;
    end
    if (cmd.emit) begin
      out_hit     <= res_hit;
      out_fault   <= res_fault;
      out_frame   <= cpr_pkg::FRAME_W'(res_frame);
      out_evicted <= cpr_pkg::PAGE_W'(res_evicted);
      out_total   <= res_total;
      out_last    <= last_ref;
    end
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= nf)
    else $error("filled frame count exceeds active frame count");

  a_hand_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(hand) < nf)
    else $error("hand points past the active frames");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_fault))
    else $error("result marks both a hit and a fault");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_fault) |-> (out_evicted == '0))
    else $error("evicted page reported without a replacement");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    cmd.do_evict |-> (used == nf))
    else $error("replacement while a free frame remains");

endmodule
